FILE: design/vmpt_pkg.sv
// vmpt_pkg: shared types, widths and codes for the vertex modelview/projection transform
// used by every module of the block and by its checker
`default_nettype none

package vmpt_pkg;

    localparam int FRAC_BITS = 16;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int SHIFT_W = PROD_W - FRAC_BITS;   // product after the fraction shift
    localparam int PAIR_W  = SHIFT_W + 1;          // sum of two shifted products
    localparam int SUM_W   = SHIFT_W + 2;          // sum of four shifted products
    localparam int IDX_W   = 4;
    localparam int NUM_LANES = 4;
    localparam int NUM_COEFFS = NUM_LANES * NUM_LANES;

    localparam int S_TDATA_W = 168;   // 164 bits of fields, zero filled to whole bytes
    localparam int M_TDATA_W = NUM_LANES * WORD_W;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] COEFF_ONE = WORD_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        KIND_LOAD_MV   = 2'd0,
        KIND_LOAD_PROJ = 2'd1,
        KIND_VERTEX    = 2'd2
    } kind_t;

    typedef logic [NUM_LANES-1:0][WORD_W-1:0]  vec_t;
    typedef logic [NUM_COEFFS-1:0][WORD_W-1:0] mat_t;

    // one pipeline slot: what a transaction carries besides the lane data
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] val;
    } ctrl_t;

    function automatic mat_t identity_mat();
        mat_t m;
        for (int i = 0; i < NUM_COEFFS; i++) begin
            m[i] = (i % (NUM_LANES + 1) == 0) ? COEFF_ONE : '0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: design/vmpt_coeff_store.sv
// vmpt_coeff_store: one 4x4 coefficient matrix, reset to identity, one write port
// depends on vmpt_pkg
`default_nettype none

module vmpt_coeff_store (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [vmpt_pkg::IDX_W-1:0] wr_idx,
    input  wire logic [vmpt_pkg::WORD_W-1:0] wr_data,
    output vmpt_pkg::mat_t                  coeffs
);
    import vmpt_pkg::*;

    mat_t coeff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= identity_mat();
        end else if (wr_en) begin
            coeff_reg[wr_idx] <= wr_data;
        end
    end

    assign coeffs = coeff_reg;

endmodule

`default_nettype wire

FILE: design/vmpt_lane.sv
// vmpt_lane: one dot-product lane, four multiplies, pair adds, final add with saturation
// three register stages, all advanced by en; depends on vmpt_pkg
`default_nettype none

module vmpt_lane (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire vmpt_pkg::vec_t              vec,
    input  wire vmpt_pkg::vec_t              col,
    output logic [vmpt_pkg::WORD_W-1:0]      res
);
    import vmpt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [NUM_LANES];
    logic signed [PROD_W-1:0] prod_next [NUM_LANES];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [WORD_W-1:0] res_reg;
    logic signed [WORD_W-1:0] res_next;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            prod_next[k] = $signed(vec[k]) * $signed(col[k]);
        end
    end

    // floor shift of each product, then pairwise add
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            pair_next[j] = PAIR_W'(SHIFT_W'(prod_reg[2*j] >>> FRAC_BITS))
                         + PAIR_W'(SHIFT_W'(prod_reg[2*j+1] >>> FRAC_BITS));
        end
    end

    always_comb begin
        sum = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        if (sum > SUM_W'(WORD_MAX)) begin
            res_next = WORD_MAX;
        end else if (sum < SUM_W'(WORD_MIN)) begin
            res_next = WORD_MIN;
        end else begin
            res_next = WORD_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            pair_reg <= pair_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: design/vmpt_merge.sv
// vmpt_merge: packs the four lane results into one result transaction
// output register plus skid register; depends on vmpt_pkg
`default_nettype none

module vmpt_merge (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    input  wire vmpt_pkg::vec_t                  in_data,
    output logic                                 in_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [vmpt_pkg::M_TDATA_W-1:0]       m_tdata
);
    import vmpt_pkg::*;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg;
    logic [M_TDATA_W-1:0] skid_data_next;
    logic                 take;

    assign take = in_valid && !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !m_tready) begin
            if (take) begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = take;
            out_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: design/vertex_modelview_projection_transform.sv
// vertex_modelview_projection_transform: top level, modelview then projection 4x4 transform
// depends on vmpt_pkg, vmpt_coeff_store, vmpt_lane, vmpt_merge
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tuser kind, s_tdata index, value, x,y,z,w
//  m_       | out       | m_tvalid/m_tready  | m_tdata clip x,y,z,w
//
// one transaction accepted per clock while the skid register is empty; a vertex result
// passes through the input register, two banks of four lanes with three stages each
// (multiply, pair add, add and saturate), and the output register
// load transactions travel the pipeline and write their matrix at the stage that reads it
// synchronous active-low reset clears pipeline valids and sets both matrices to identity
// the whole pipeline holds only while the skid register is full
`default_nettype none

module vertex_modelview_projection_transform (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [3:0] coeff_index, [35:4] coeff_value, [67:36] vertex_x, [99:68] vertex_y,
    // [131:100] vertex_z, [163:132] vertex_w, [167:164] zero
    input  wire logic [vmpt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] clip_x, [63:32] clip_y, [95:64] clip_z, [127:96] clip_w
    output logic [vmpt_pkg::M_TDATA_W-1:0]       m_tdata
);
    import vmpt_pkg::*;

    logic  adv;
    logic  accept;
    ctrl_t s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg, s4_ctrl_reg;
    ctrl_t s1_ctrl_next;
    logic  s5_vert_reg, s6_vert_reg, s7_vert_reg;
    vec_t  s1_vec_reg;
    vec_t  mid;
    vec_t  clip;
    mat_t  mv_coeffs;
    mat_t  proj_coeffs;
    logic  mv_we;
    logic  proj_we;

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    always_comb begin
        s1_ctrl_next.valid = accept;
        s1_ctrl_next.kind  = kind_t'(s_tuser);
        s1_ctrl_next.idx   = s_tdata[IDX_W-1:0];
        s1_ctrl_next.val   = s_tdata[IDX_W +: WORD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
            s4_ctrl_reg <= '0;
            s5_vert_reg <= 1'b0;
            s6_vert_reg <= 1'b0;
            s7_vert_reg <= 1'b0;
        end else if (adv) begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
            s4_ctrl_reg <= s3_ctrl_reg;
            s5_vert_reg <= s4_ctrl_reg.valid && (s4_ctrl_reg.kind == KIND_VERTEX);
            s6_vert_reg <= s5_vert_reg;
            s7_vert_reg <= s6_vert_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                s1_vec_reg[k] <= s_tdata[IDX_W + WORD_W + k*WORD_W +: WORD_W];
            end
        end
    end

    assign mv_we   = adv && s1_ctrl_reg.valid && (s1_ctrl_reg.kind == KIND_LOAD_MV);
    assign proj_we = adv && s4_ctrl_reg.valid && (s4_ctrl_reg.kind == KIND_LOAD_PROJ);

    vmpt_coeff_store u_mv_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mv_we),
        .wr_idx  (s1_ctrl_reg.idx),
        .wr_data (s1_ctrl_reg.val),
        .coeffs  (mv_coeffs)
    );

    vmpt_coeff_store u_proj_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (proj_we),
        .wr_idx  (s4_ctrl_reg.idx),
        .wr_data (s4_ctrl_reg.val),
        .coeffs  (proj_coeffs)
    );

    // lane i takes column i of each matrix: element 4k+i
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        vec_t mv_col;
        vec_t proj_col;

        for (genvar k = 0; k < NUM_LANES; k++) begin : g_col
            assign mv_col[k]   = mv_coeffs[NUM_LANES*k + i];
            assign proj_col[k] = proj_coeffs[NUM_LANES*k + i];
        end

        vmpt_lane u_mv_lane (
            .aclk (aclk),
            .en   (adv),
            .vec  (s1_vec_reg),
            .col  (mv_col),
            .res  (mid[i])
        );

        vmpt_lane u_proj_lane (
            .aclk (aclk),
            .en   (adv),
            .vec  (mid),
            .col  (proj_col),
            .res  (clip[i])
        );
    end

    vmpt_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s7_vert_reg),
        .in_data  (clip),
        .in_ready (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: design/vmpt_checker.sv
// vmpt_checker: port-level assertions for the vertex transform, bound to the top level
// depends on vmpt_pkg and vertex_modelview_projection_transform
`default_nettype none

module vmpt_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [1:0]                      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [vmpt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import vmpt_pkg::*;

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       vert_in;
    logic       res_out;

    assign vert_in = s_tvalid && s_tready && (s_tuser == KIND_VERTEX);
    assign res_out = m_tvalid && m_tready;

    // vertex transactions accepted but not yet delivered
    always_comb begin
        pending_next = pending_reg;
        if (vert_in && !res_out) begin
            pending_next = pending_reg + 4'd1;
        end else if (res_out && !vert_in) begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result offered with no vertex outstanding");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while no result is waiting");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 4'd9 |-> !vert_in || res_out)
        else $error("more vertices in flight than the pipeline holds");

endmodule

bind vertex_modelview_projection_transform vmpt_checker u_vmpt_checker (.*);

`default_nettype wire

FILE: test/tb_vertex_modelview_projection_transform.sv
// tb_vertex_modelview_projection_transform: self-checking bench for the vertex transform,
// with directed and random load/vertex streams, random idling and output back-pressure
// depends on vmpt_pkg and vertex_modelview_projection_transform
`timescale 1ns / 100ps

module tb_vertex_modelview_projection_transform;
    import vmpt_pkg::*;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int Q_ONE = 1 << FRAC_BITS;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES = 300;

    // keeps both coefficient stores and the clip results still owed by the block
    class clip_predictor;
        mat_t modelview;
        mat_t projection;
        vec_t pending_clip[$];
        int failures;
        int loads;
        int vertices;
        int ignored;
        int clips_checked;

        function new();
            for (int i = 0; i < NUM_COEFFS; i++) begin
                modelview[i]  = (i % 5 == 0) ? WORD_W'(Q_ONE) : '0;
                projection[i] = (i % 5 == 0) ? WORD_W'(Q_ONE) : '0;
            end
            failures = 0;
            loads = 0;
            vertices = 0;
            ignored = 0;
            clips_checked = 0;
        endfunction

        function logic [WORD_W-1:0] clamp_word(longint s);
            if (s > longint'(WORD_MAX)) return WORD_MAX;
            if (s < longint'(WORD_MIN)) return WORD_MIN;
            return s[WORD_W-1:0];
        endfunction

        // r_i = sum_k v_k * m[4k+i], each product floored by the fraction shift
        function vec_t transform_by(mat_t m, vec_t v);
            vec_t r;
            longint acc;
            for (int i = 0; i < NUM_LANES; i++) begin
                acc = 0;
                for (int k = 0; k < NUM_LANES; k++) begin
                    acc += (longint'($signed(v[k])) * longint'($signed(m[4*k+i])))
                           >>> FRAC_BITS;
                end
                r[i] = clamp_word(acc);
            end
            return r;
        endfunction

        function void note_transaction(logic [1:0] kind, logic [S_TDATA_W-1:0] d);
            case (kind)
                KIND_LOAD_MV: begin
                    modelview[d[3:0]] = d[35:4];
                    loads++;
                end
                KIND_LOAD_PROJ: begin
                    projection[d[3:0]] = d[35:4];
                    loads++;
                end
                KIND_VERTEX: begin
                    pending_clip.push_back(transform_by(projection,
                                                        transform_by(modelview, d[163:36])));
                    vertices++;
                end
                default: ignored++;
            endcase
        endfunction

        function void check_clip(logic [M_TDATA_W-1:0] d);
            vec_t want;
            if (pending_clip.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: clip result %h with none outstanding", $realtime, d);
                return;
            end
            want = pending_clip.pop_front();
            clips_checked++;
            for (int i = 0; i < NUM_LANES; i++) begin
                if (d[i*WORD_W +: WORD_W] !== want[i]) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: clip lane %0d (x,y,z,w) expected %h actual %h",
                                 $realtime, i, want[i], d[i*WORD_W +: WORD_W]);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    clip_predictor pred = new();
    int items_sent = 0;
    int stall_cycles = 0;
    bit pressure_done = 1'b0;

    vertex_modelview_projection_transform dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function bit quiet_phase();
        return items_sent >= 300 && items_sent < 500;
    endfunction

    // mostly modest values so the results stay in range, sometimes the whole word
    function logic [WORD_W-1:0] rand_coeff();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return WORD_W'(int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE);
        if (pick < 90) return WORD_W'(int'($urandom_range(0, 256 * Q_ONE)) - 128 * Q_ONE);
        return $urandom;
    endfunction

    function logic [WORD_W-1:0] rand_component();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return WORD_W'(int'($urandom_range(0, 200 * Q_ONE)) - 100 * Q_ONE);
        if (pick < 90) return WORD_W'(int'($urandom_range(0, 32767 * Q_ONE)) - 16383 * Q_ONE);
        return $urandom;
    endfunction

    task automatic send_transaction(logic [1:0] kind, logic [S_TDATA_W-1:0] d);
        while (!quiet_phase() && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_load(kind_t kind, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        logic [4*WORD_W-1:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        send_transaction(kind, {4'b0, noise, val, idx});
    endtask

    task automatic send_vertex(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                               logic [WORD_W-1:0] z, logic [WORD_W-1:0] w);
        logic [2*WORD_W-1:0] noise;
        noise = {$urandom, $urandom};
        send_transaction(KIND_VERTEX, {4'b0, w, z, y, x, noise[IDX_W+WORD_W-1:0]});
    endtask

    // scoreboard feed and stall watch
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pred.note_transaction(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                pred.check_clip(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_vertex_modelview_projection_transform failed");
        $finish;
    end

    // result side: random back-pressure, one quiet stretch and one long hold-off
    initial begin
        int hold;
        hold = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (!pressure_done && items_sent >= 700) begin
                pressure_done = 1'b1;
                hold = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (quiet_phase()) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 33);
            end
        end
    end

    initial begin
        int random_items;
        int pick;
        logic [S_TDATA_W-1:0] junk;
        kind_t which;

        random_items = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity stores pass the vertex through, extremes included
        send_vertex(Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE);
        send_vertex(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_vertex(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_vertex(WORD_MAX, WORD_MIN, '0, '1);
        junk = '1;
        junk[167:164] = '0;
        send_transaction(KIND_IGNORED, junk);
        // half a unit times a tiny negative must floor
        send_load(KIND_LOAD_MV, 4'd0, WORD_W'(Q_ONE / 2));
        send_vertex('1, 3, -5, 7);
        send_load(KIND_LOAD_MV, 4'd15, WORD_MAX);
        send_load(KIND_LOAD_MV, 4'd5, WORD_MIN);
        send_load(KIND_LOAD_PROJ, 4'd0, WORD_MIN);
        send_load(KIND_LOAD_PROJ, 4'd15, WORD_MAX);
        // saturation towards both ends
        send_vertex(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        send_vertex(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
        send_load(KIND_LOAD_PROJ, 4'd4, WORD_W'(-Q_ONE));
        send_vertex('0, '0, '0, '0);
        send_vertex(-Q_ONE, 2 * Q_ONE, Q_ONE, -7);
        // back towards identity
        send_load(KIND_LOAD_MV, 4'd0, WORD_W'(Q_ONE));
        send_load(KIND_LOAD_MV, 4'd5, WORD_W'(Q_ONE));
        send_load(KIND_LOAD_MV, 4'd15, WORD_W'(Q_ONE));
        send_load(KIND_LOAD_PROJ, 4'd0, WORD_W'(Q_ONE));
        send_load(KIND_LOAD_PROJ, 4'd4, '0);
        send_load(KIND_LOAD_PROJ, 4'd15, WORD_W'(Q_ONE));
        send_vertex(rand_component(), rand_component(), rand_component(), rand_component());

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            which = $urandom_range(1) ? KIND_LOAD_PROJ : KIND_LOAD_MV;
            if (pick < 4) begin
                // whole matrix reprogrammed in order
                for (int i = 0; i < NUM_COEFFS; i++)
                    send_load(which, IDX_W'(i), rand_coeff());
                random_items += NUM_COEFFS;
            end else if (pick < 24) begin
                send_load(which, IDX_W'($urandom_range(15)), rand_coeff());
                random_items++;
            end else if (pick < 29) begin
                junk = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                junk[167:164] = '0;
                send_transaction(KIND_IGNORED, junk);
            end else begin
                send_vertex(rand_component(), rand_component(), rand_component(),
                            rand_component());
                random_items++;
            end
        end
        s_tvalid <= 1'b0;
        // let the scoreboard note the last accepted transaction first
        @(posedge aclk);

        while (pred.pending_clip.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d coefficient loads, %0d vertices and %0d ignored transactions",
                 pred.loads, pred.vertices, pred.ignored);
        $display("checked %0d clip results, %0d failures", pred.clips_checked, pred.failures);
        if (pred.failures == 0 && pred.pending_clip.size() == 0)
            $display("tb_vertex_modelview_projection_transform passed");
        else
            $display("tb_vertex_modelview_projection_transform failed");
        $finish;
    end

endmodule
